// ===== hdl/tni_pkg.sv =====
// Shared types, codes and saturating Q32.32 helpers of the thermal network integrator.
// No dependencies; imported by tni_alu, thermal_network_integrator, tni_checker and testbench.
package tni_pkg;

    // Item function codes
    localparam logic [1:0] FN_OP    = 2'd0;
    localparam logic [1:0] FN_WRITE = 2'd1;
    localparam logic [1:0] FN_RUN   = 2'd2;
    localparam logic [1:0] FN_READ  = 2'd3;

    // Operation kinds
    localparam logic [2:0] K_COUPLE = 3'd0;
    localparam logic [2:0] K_SINK   = 3'd1;
    localparam logic [2:0] K_HEAT   = 3'd2;
    localparam logic [2:0] K_PHEAT  = 3'd3;
    localparam logic [2:0] K_THEAT  = 3'd4;

    // Result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_SAT   = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_TIME = 2'd0;
    localparam logic [1:0] CFG_PRED = 2'd1;
    localparam logic [1:0] CFG_OPS  = 2'd2;
    localparam logic [1:0] CFG_STEP = 2'd3;

    localparam logic signed [63:0] Q_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] Q_MIN = 64'sh8000_0000_0000_0000;

    // One entry of the operation table
    typedef struct packed {
        logic [2:0]         kind;
        logic [5:0]         power;
        logic [5:0]         source;
        logic [5:0]         target;
        logic signed [63:0] c1;
        logic signed [63:0] c2;
    } tni_op_t;

    localparam int OP_W = $bits(tni_op_t);

    // Saturating result with its flag
    typedef struct packed {
        logic               sat;
        logic signed [63:0] val;
    } tni_sres_t;

    // Arithmetic unit request and status
    typedef struct packed {
        logic start;
        logic div;
    } tni_alu_req_t;

    typedef struct packed {
        logic done;
        logic sat;
    } tni_alu_stat_t;

    function automatic tni_sres_t q_add(input logic signed [63:0] a,
                                        input logic signed [63:0] b);
        logic signed [64:0] s;
        tni_sres_t r;
        s = {a[63], a} + {b[63], b};
        r.sat = (s[64] != s[63]);
        r.val = r.sat ? (s[64] ? Q_MIN : Q_MAX) : s[63:0];
        return r;
    endfunction

    function automatic tni_sres_t q_sub(input logic signed [63:0] a,
                                        input logic signed [63:0] b);
        logic signed [64:0] s;
        tni_sres_t r;
        s = {a[63], a} - {b[63], b};
        r.sat = (s[64] != s[63]);
        r.val = r.sat ? (s[64] ? Q_MIN : Q_MAX) : s[63:0];
        return r;
    endfunction

    // Halve, truncating toward zero
    function automatic logic signed [63:0] q_half(input logic signed [63:0] x);
        logic signed [63:0] t;
        t = x + {63'd0, x[63]};
        return t >>> 1;
    endfunction

    // Apply sign to a magnitude, saturating
    function automatic tni_sres_t signed_from(input logic [63:0] m, input logic neg,
                                              input logic over);
        tni_sres_t r;
        if (neg) begin
            r.sat = over || (m > 64'h8000_0000_0000_0000);
            r.val = r.sat ? Q_MIN : -$signed(m);
        end
        else begin
            r.sat = over || m[63];
            r.val = r.sat ? Q_MAX : $signed(m);
        end
        return r;
    endfunction

endpackage

// ===== hdl/tni_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module tni_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic                                  re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

// ===== hdl/tni_alu.sv =====
// Shared multi-cycle Q32.32 multiplier (four 32x32 partial products) and
// bit-serial divider (one quotient bit a cycle). Depends on tni_pkg.
module tni_alu (
    input  logic                   clk,
    input  logic                   rst_n,
    input  tni_pkg::tni_alu_req_t  req,
    input  logic signed [63:0]     a,
    input  logic signed [63:0]     b,
    output tni_pkg::tni_alu_stat_t stat,
    output logic signed [63:0]     result
);
    import tni_pkg::*;

    localparam logic [2:0] A_IDLE = 3'd0;
    localparam logic [2:0] A_MUL  = 3'd1;
    localparam logic [2:0] A_DIV  = 3'd2;
    localparam logic [2:0] A_FIN  = 3'd3;
    localparam logic [2:0] A_OUT  = 3'd4;

    logic [2:0]         st_reg, st_next;
    logic [5:0]         cnt_reg, cnt_next;
    logic [63:0]        ua_reg, ua_next, ub_reg, ub_next;
    logic               neg_reg, neg_next, div_reg, div_next;
    logic [63:0]        pp_reg, pp_next;
    logic [1:0]         sh_reg, sh_next;
    logic [127:0]       acc_reg, acc_next;
    logic [63:0]        r_reg, r_next, lo_reg, lo_next, q_reg, q_next;
    logic signed [63:0] res_reg, res_next;
    logic               sat_reg, sat_next;

    logic [63:0]  ma, mb, r2, ha, hb;
    logic [127:0] pp_sh;
    tni_sres_t    fin;

    assign ma = a[63] ? (64'd0 - a) : a;
    assign mb = b[63] ? (64'd0 - b) : b;
    assign ha = cnt_reg[1] ? {32'd0, ua_reg[63:32]} : {32'd0, ua_reg[31:0]};
    assign hb = cnt_reg[0] ? {32'd0, ub_reg[63:32]} : {32'd0, ub_reg[31:0]};
    assign r2 = {r_reg[62:0], lo_reg[63]};

    // Place the previous partial product
    always_comb
    begin
        case (sh_reg)
            2'd1:    pp_sh = {32'd0, pp_reg, 32'd0};
            2'd2:    pp_sh = {pp_reg, 64'd0};
            default: pp_sh = {64'd0, pp_reg};
        endcase
    end

    assign fin = div_reg ? signed_from(q_reg, neg_reg, 1'b0)
                         : signed_from(acc_reg[95:32], neg_reg, |acc_reg[127:96]);

    // Sequence multiply and divide
    always_comb
    begin
        st_next  = st_reg;
        cnt_next = cnt_reg;
        ua_next  = ua_reg;
        ub_next  = ub_reg;
        neg_next = neg_reg;
        div_next = div_reg;
        pp_next  = pp_reg;
        sh_next  = sh_reg;
        acc_next = acc_reg;
        r_next   = r_reg;
        lo_next  = lo_reg;
        q_next   = q_reg;
        res_next = res_reg;
        sat_next = sat_reg;
        unique case (st_reg)
            A_IDLE:
            begin
                if (req.start)
                begin
                    ua_next  = ma;
                    ub_next  = mb;
                    neg_next = a[63] ^ b[63];
                    div_next = req.div;
                    cnt_next = '0;
                    acc_next = '0;
                    q_next   = '0;
                    if (!req.div)
                    begin
                        st_next = A_MUL;
                    end
                    else if (b == 64'sd0)
                    begin
                        res_next = a[63] ? Q_MIN : Q_MAX;
                        sat_next = 1'b1;
                        st_next  = A_OUT;
                    end
                    else if ({32'd0, ma[63:32]} >= mb)
                    begin
                        res_next = (a[63] ^ b[63]) ? Q_MIN : Q_MAX;
                        sat_next = 1'b1;
                        st_next  = A_OUT;
                    end
                    else
                    begin
                        r_next  = {32'd0, ma[63:32]};
                        lo_next = {ma[31:0], 32'd0};
                        st_next = A_DIV;
                    end
                end
            end
            A_MUL:
            begin
                if (cnt_reg != 6'd4)
                begin
                    pp_next = ha[31:0] * hb[31:0];
                    sh_next = {1'b0, cnt_reg[1]} + {1'b0, cnt_reg[0]};
                end
                if (cnt_reg != 6'd0)
                begin
                    acc_next = acc_reg + pp_sh;
                end
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd4)
                begin
                    st_next = A_FIN;
                end
            end
            A_DIV:
            begin
                if (r_reg[63] || (r2 >= ub_reg))
                begin
                    r_next = r2 - ub_reg;
                    q_next = {q_reg[62:0], 1'b1};
                end
                else
                begin
                    r_next = r2;
                    q_next = {q_reg[62:0], 1'b0};
                end
                lo_next  = {lo_reg[62:0], 1'b0};
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd63)
                begin
                    st_next = A_FIN;
                end
            end
            A_FIN:
            begin
                res_next = fin.val;
                sat_next = fin.sat;
                st_next  = A_OUT;
            end
            A_OUT:
            begin
                st_next = A_IDLE;
            end
            default:
            begin
                st_next = A_IDLE;
            end
        endcase
    end

    // Hold control and datapath state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= A_IDLE;
        end
        else
        begin
            st_reg <= st_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg <= cnt_next;
        ua_reg  <= ua_next;
        ub_reg  <= ub_next;
        neg_reg <= neg_next;
        div_reg <= div_next;
        pp_reg  <= pp_next;
        sh_reg  <= sh_next;
        acc_reg <= acc_next;
        r_reg   <= r_next;
        lo_reg  <= lo_next;
        q_reg   <= q_next;
        res_reg <= res_next;
        sat_reg <= sat_next;
    end

    assign stat.done = (st_reg == A_OUT);
    assign stat.sat  = sat_reg;
    assign result    = res_reg;
endmodule

// ===== hdl/thermal_network_integrator.sv =====
// Thermal network integrator: value store, operation table and run sequencer.
// Op and store writes load their result as they are taken; a store read first passes
// the registered RAM read. Per column pair a run loads the predicted nodes, evaluates
// the ops, half-steps, evaluates again and updates, on the serial divider and multiplier.
// One item at a time; a waiting result holds off the next item until it is taken.
// Reset clears control and configuration registers; memories hold garbage until written.
module thermal_network_integrator #(
    parameter int MAX_ROWS  = 64,
    parameter int MAX_TIMES = 256,
    parameter int MAX_OPS   = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         func,
    input  logic [5:0]         op_index,
    input  logic [2:0]         op_kind,
    input  logic [5:0]         target_node,
    input  logic [5:0]         source_node,
    input  logic [5:0]         power_row,
    input  logic signed [63:0] coef_first,
    input  logic signed [63:0] coef_second,
    input  logic [5:0]         row,
    input  logic [7:0]         column,
    input  logic signed [63:0] value,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [63:0] read_value,
    output logic [1:0]         status,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [63:0]        cfg_data
);
    import tni_pkg::*;

    localparam int SDEPTH = MAX_ROWS * MAX_TIMES;
    localparam int SAW    = $clog2(SDEPTH);
    localparam int RW     = $clog2(MAX_ROWS);
    localparam int OW     = (MAX_OPS > 1) ? $clog2(MAX_OPS) : 1;
    localparam int TCW    = $clog2(MAX_TIMES + 1);
    localparam int CW     = $clog2(MAX_ROWS + 1);
    localparam int OCW    = $clog2(MAX_OPS + 1);

    localparam logic [4:0] S_IDLE    = 5'd0;
    localparam logic [4:0] S_READ    = 5'd1;
    localparam logic [4:0] S_PAIR    = 5'd2;
    localparam logic [4:0] S_S0_RD   = 5'd3;
    localparam logic [4:0] S_S0_WR   = 5'd4;
    localparam logic [4:0] S_EV_OP   = 5'd5;
    localparam logic [4:0] S_EV_DEC  = 5'd6;
    localparam logic [4:0] S_EV_SRC  = 5'd7;
    localparam logic [4:0] S_EV_TGT  = 5'd8;
    localparam logic [4:0] S_EV_WAIT = 5'd9;
    localparam logic [4:0] S_EV_HEAT = 5'd10;
    localparam logic [4:0] S_EV_ACC  = 5'd11;
    localparam logic [4:0] S_S1_RD   = 5'd12;
    localparam logic [4:0] S_S1_MUL  = 5'd13;
    localparam logic [4:0] S_S1_WAIT = 5'd14;
    localparam logic [4:0] S_FN_RD   = 5'd15;
    localparam logic [4:0] S_FN_MUL  = 5'd16;
    localparam logic [4:0] S_FN_WAIT = 5'd17;
    localparam logic [4:0] S_FN_W2   = 5'd18;
    localparam logic [4:0] S_DONE    = 5'd19;

    localparam logic [1:0] SRC_TEMP  = 2'd0;
    localparam logic [1:0] SRC_STORE = 2'd1;
    localparam logic [1:0] SRC_ZERO  = 2'd2;

    function automatic logic [SAW-1:0] st_addr(input logic [31:0] r, input logic [31:0] c);
        logic [31:0] t;
        t = r * MAX_TIMES + c;
        return t[SAW-1:0];
    endfunction

    // Configuration registers
    logic [8:0]  time_count_reg;
    logic [6:0]  pred_count_reg, op_count_reg;
    logic [62:0] step_size_reg;

    // Sequencer registers
    logic [4:0]         state_reg, state_next;
    logic [TCW-1:0]     tc_reg, tc_next, j0_reg, j0_next;
    logic [CW-1:0]      np_reg, np_next, idx_reg, idx_next;
    logic [OCW-1:0]     nops_reg, nops_next, k_reg, k_next;
    logic               stage_reg, stage_next, sat_reg, sat_next;
    logic signed [63:0] dt_reg, dt_next;
    tni_op_t            op_reg, op_next;
    logic [1:0]         src_sel_reg, src_sel_next;
    logic signed [63:0] src_reg, src_next, tmp_reg, tmp_next, drv_reg, drv_next;
    logic signed [63:0] add_reg, add_next, k2_reg, k2_next;
    logic               heat_on_reg, heat_on_next;

    // Output register
    logic               out_valid_reg, out_ld;
    logic signed [63:0] rv_reg, rv_d;
    logic [1:0]         st_reg, st_d;

    // Memory ports
    logic               st_we, st_re, op_we, op_re, tp_we, tp_re, dv_we, dv_re;
    logic [SAW-1:0]     st_waddr, st_raddr;
    logic [63:0]        st_wdata, st_rdata;
    logic [OW-1:0]      op_waddr, op_raddr;
    logic [OP_W-1:0]    op_wdata, op_rdata;
    logic [RW-1:0]      tp_waddr, tp_raddr, dv_waddr, dv_raddr;
    logic [63:0]        tp_wdata, tp_rdata, dv_wdata, dv_rdata;

    // Arithmetic unit
    tni_alu_req_t       alu_req;
    tni_alu_stat_t      alu_stat;
    logic signed [63:0] alu_a, alu_b, alu_res;

    logic        in_acc;
    logic [31:0] col;
    tni_op_t     op_cur;
    tni_sres_t   ar_s, ar_d;
    logic        t_pred;

    assign in_ready  = (state_reg == S_IDLE) && (!out_valid_reg || out_ready);
    assign in_acc    = in_valid && in_ready;
    assign cfg_ready = 1'b1;
    assign col       = 32'(j0_reg) + 32'(stage_reg);
    assign op_cur    = tni_op_t'(op_rdata);
    assign t_pred    = 32'(op_reg.target) < 32'(np_reg);

    tni_ram #(.WIDTH(64), .DEPTH(SDEPTH)) u_store (
        .clk(clk), .we(st_we), .waddr(st_waddr), .wdata(st_wdata),
        .re(st_re), .raddr(st_raddr), .rdata(st_rdata)
    );

    tni_ram #(.WIDTH(OP_W), .DEPTH(MAX_OPS)) u_ops (
        .clk(clk), .we(op_we), .waddr(op_waddr), .wdata(op_wdata),
        .re(op_re), .raddr(op_raddr), .rdata(op_rdata)
    );

    tni_ram #(.WIDTH(64), .DEPTH(MAX_ROWS)) u_temps (
        .clk(clk), .we(tp_we), .waddr(tp_waddr), .wdata(tp_wdata),
        .re(tp_re), .raddr(tp_raddr), .rdata(tp_rdata)
    );

    tni_ram #(.WIDTH(64), .DEPTH(MAX_ROWS)) u_derivs (
        .clk(clk), .we(dv_we), .waddr(dv_waddr), .wdata(dv_wdata),
        .re(dv_re), .raddr(dv_raddr), .rdata(dv_rdata)
    );

    tni_alu u_alu (
        .clk(clk), .rst_n(rst_n), .req(alu_req), .a(alu_a), .b(alu_b),
        .stat(alu_stat), .result(alu_res)
    );

    // Sequence items and the run
    always_comb
    begin
        state_next   = state_reg;
        tc_next      = tc_reg;
        j0_next      = j0_reg;
        np_next      = np_reg;
        idx_next     = idx_reg;
        nops_next    = nops_reg;
        k_next       = k_reg;
        stage_next   = stage_reg;
        sat_next     = sat_reg;
        dt_next      = dt_reg;
        op_next      = op_reg;
        src_sel_next = src_sel_reg;
        src_next     = src_reg;
        tmp_next     = tmp_reg;
        drv_next     = drv_reg;
        add_next     = add_reg;
        k2_next      = k2_reg;
        heat_on_next = heat_on_reg;
        out_ld = 1'b0;
        rv_d   = '0;
        st_d   = ST_OK;
        st_we = 1'b0; st_waddr = '0; st_wdata = '0; st_re = 1'b0; st_raddr = '0;
        op_we = 1'b0; op_waddr = '0; op_wdata = '0; op_re = 1'b0; op_raddr = '0;
        tp_we = 1'b0; tp_waddr = '0; tp_wdata = '0; tp_re = 1'b0; tp_raddr = '0;
        dv_we = 1'b0; dv_waddr = '0; dv_wdata = '0; dv_re = 1'b0; dv_raddr = '0;
        alu_req = '0;
        alu_a   = '0;
        alu_b   = '0;
        ar_s    = '0;
        ar_d    = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    unique case (func)
                        FN_OP:
                        begin
                            out_ld = 1'b1;
                            if (32'(op_index) >= MAX_OPS)
                            begin
                                st_d = ST_RANGE;
                            end
                            else
                            begin
                                op_we    = 1'b1;
                                op_waddr = OW'(op_index);
                                op_wdata = {op_kind, power_row, source_node, target_node,
                                            coef_first, coef_second};
                            end
                        end
                        FN_WRITE:
                        begin
                            out_ld = 1'b1;
                            if (32'(row) >= MAX_ROWS || 32'(column) >= MAX_TIMES)
                            begin
                                st_d = ST_RANGE;
                            end
                            else
                            begin
                                st_we    = 1'b1;
                                st_waddr = st_addr(32'(row), 32'(column));
                                st_wdata = value;
                            end
                        end
                        FN_READ:
                        begin
                            if (32'(row) >= MAX_ROWS || 32'(column) >= MAX_TIMES)
                            begin
                                out_ld = 1'b1;
                                st_d   = ST_RANGE;
                            end
                            else
                            begin
                                st_re      = 1'b1;
                                st_raddr   = st_addr(32'(row), 32'(column));
                                state_next = S_READ;
                            end
                        end
                        FN_RUN:
                        begin
                            tc_next   = (32'(time_count_reg) > MAX_TIMES) ?
                                        TCW'(MAX_TIMES) : TCW'(time_count_reg);
                            np_next   = (32'(pred_count_reg) > MAX_ROWS) ?
                                        CW'(MAX_ROWS) : CW'(pred_count_reg);
                            nops_next = (32'(op_count_reg) > MAX_OPS) ?
                                        OCW'(MAX_OPS) : OCW'(op_count_reg);
                            dt_next    = {1'b0, step_size_reg};
                            j0_next    = '0;
                            sat_next   = 1'b0;
                            state_next = S_PAIR;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_READ:
            begin
                out_ld     = 1'b1;
                rv_d       = st_rdata;
                state_next = S_IDLE;
            end
            S_PAIR:
            begin
                if (32'(j0_reg) + 32'd2 < 32'(tc_reg))
                begin
                    stage_next = 1'b0;
                    idx_next   = '0;
                    state_next = S_S0_RD;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_S0_RD:
            begin
                if (idx_reg == np_reg)
                begin
                    k_next     = '0;
                    state_next = S_EV_OP;
                end
                else
                begin
                    st_re      = 1'b1;
                    st_raddr   = st_addr(32'(idx_reg), col);
                    state_next = S_S0_WR;
                end
            end
            S_S0_WR:
            begin
                tp_we      = 1'b1;
                tp_waddr   = RW'(idx_reg);
                tp_wdata   = st_rdata;
                dv_we      = 1'b1;
                dv_waddr   = RW'(idx_reg);
                idx_next   = idx_reg + CW'(1);
                state_next = S_S0_RD;
            end
            S_EV_OP:
            begin
                if (k_reg == nops_reg)
                begin
                    idx_next = '0;
                    if (!stage_reg)
                    begin
                        stage_next = 1'b1;
                        state_next = S_S1_RD;
                    end
                    else
                    begin
                        state_next = S_FN_RD;
                    end
                end
                else
                begin
                    op_re      = 1'b1;
                    op_raddr   = OW'(k_reg);
                    state_next = S_EV_DEC;
                end
            end
            S_EV_DEC:
            begin
                op_next = op_cur;
                // Drop unknown kinds and derivative-only ops on non-predicted targets
                if (op_cur.kind > K_THEAT ||
                    (op_cur.kind <= K_HEAT && 32'(op_cur.target) >= 32'(np_reg)))
                begin
                    k_next     = k_reg + OCW'(1);
                    state_next = S_EV_OP;
                end
                else
                begin
                    if (op_cur.kind != K_HEAT && 32'(op_cur.source) < 32'(np_reg))
                    begin
                        tp_re        = 1'b1;
                        tp_raddr     = RW'(op_cur.source);
                        src_sel_next = SRC_TEMP;
                    end
                    else if (32'(op_cur.source) < MAX_ROWS)
                    begin
                        st_re        = 1'b1;
                        st_raddr     = st_addr(32'(op_cur.source), col);
                        src_sel_next = SRC_STORE;
                    end
                    else
                    begin
                        src_sel_next = SRC_ZERO;
                    end
                    state_next = S_EV_SRC;
                end
            end
            S_EV_SRC:
            begin
                case (src_sel_reg)
                    SRC_TEMP:  src_next = tp_rdata;
                    SRC_STORE: src_next = st_rdata;
                    default:   src_next = '0;
                endcase
                tp_re      = 1'b1;
                tp_raddr   = RW'(op_reg.target);
                dv_re      = 1'b1;
                dv_raddr   = RW'(op_reg.target);
                state_next = S_EV_TGT;
            end
            S_EV_TGT:
            begin
                drv_next = dv_rdata;
                case (op_reg.kind) inside
                    K_COUPLE:
                    begin
                        ar_d          = q_sub(src_reg, tp_rdata);
                        alu_req.start = 1'b1;
                        alu_req.div   = 1'b1;
                        alu_a         = ar_d.val;
                        alu_b         = op_reg.c1;
                        state_next    = S_EV_WAIT;
                    end
                    K_SINK:
                    begin
                        ar_d          = q_sub(op_reg.c1, tp_rdata);
                        alu_req.start = 1'b1;
                        alu_req.div   = 1'b1;
                        alu_a         = ar_d.val;
                        alu_b         = op_reg.c2;
                        state_next    = S_EV_WAIT;
                    end
                    K_PHEAT, K_THEAT:
                    begin
                        ar_d         = q_sub(op_reg.c1, src_reg);
                        heat_on_next = !ar_d.val[63] && (ar_d.val != 64'sd0);
                        if (heat_on_next && op_reg.kind == K_PHEAT)
                        begin
                            alu_req.start = 1'b1;
                            alu_a         = op_reg.c2;
                            alu_b         = ar_d.val;
                            state_next    = S_EV_WAIT;
                        end
                        else
                        begin
                            add_next   = heat_on_next ? op_reg.c2 : 64'sd0;
                            state_next = S_EV_HEAT;
                        end
                    end
                    default:
                    begin
                        add_next   = src_reg;
                        state_next = S_EV_ACC;
                    end
                endcase
                sat_next = sat_reg | ar_d.sat;
            end
            S_EV_WAIT:
            begin
                if (alu_stat.done)
                begin
                    add_next   = alu_res;
                    sat_next   = sat_reg | alu_stat.sat;
                    state_next = (op_reg.kind == K_PHEAT) ? S_EV_HEAT : S_EV_ACC;
                end
            end
            S_EV_HEAT:
            begin
                // Write heater power, then add it to the target if predicted
                if (32'(op_reg.power) < MAX_ROWS)
                begin
                    st_we    = 1'b1;
                    st_waddr = st_addr(32'(op_reg.power), col);
                    st_wdata = add_reg;
                end
                if (heat_on_reg && t_pred)
                begin
                    state_next = S_EV_ACC;
                end
                else
                begin
                    k_next     = k_reg + OCW'(1);
                    state_next = S_EV_OP;
                end
            end
            S_EV_ACC:
            begin
                ar_s       = q_add(drv_reg, add_reg);
                sat_next   = sat_reg | ar_s.sat;
                dv_we      = 1'b1;
                dv_waddr   = RW'(op_reg.target);
                dv_wdata   = ar_s.val;
                k_next     = k_reg + OCW'(1);
                state_next = S_EV_OP;
            end
            S_S1_RD:
            begin
                if (idx_reg == np_reg)
                begin
                    k_next     = '0;
                    state_next = S_EV_OP;
                end
                else
                begin
                    tp_re      = 1'b1;
                    tp_raddr   = RW'(idx_reg);
                    dv_re      = 1'b1;
                    dv_raddr   = RW'(idx_reg);
                    state_next = S_S1_MUL;
                end
            end
            S_S1_MUL:
            begin
                tmp_next      = tp_rdata;
                alu_req.start = 1'b1;
                alu_a         = dt_reg;
                alu_b         = dv_rdata;
                state_next    = S_S1_WAIT;
            end
            S_S1_WAIT:
            begin
                if (alu_stat.done)
                begin
                    ar_s       = q_add(tmp_reg, q_half(alu_res));
                    sat_next   = sat_reg | alu_stat.sat | ar_s.sat;
                    tp_we      = 1'b1;
                    tp_waddr   = RW'(idx_reg);
                    tp_wdata   = ar_s.val;
                    dv_we      = 1'b1;
                    dv_waddr   = RW'(idx_reg);
                    idx_next   = idx_reg + CW'(1);
                    state_next = S_S1_RD;
                end
            end
            S_FN_RD:
            begin
                if (idx_reg == np_reg)
                begin
                    j0_next    = j0_reg + TCW'(2);
                    state_next = S_PAIR;
                end
                else
                begin
                    tp_re      = 1'b1;
                    tp_raddr   = RW'(idx_reg);
                    dv_re      = 1'b1;
                    dv_raddr   = RW'(idx_reg);
                    state_next = S_FN_MUL;
                end
            end
            S_FN_MUL:
            begin
                tmp_next      = tp_rdata;
                alu_req.start = 1'b1;
                alu_a         = dt_reg;
                alu_b         = dv_rdata;
                state_next    = S_FN_WAIT;
            end
            S_FN_WAIT:
            begin
                if (alu_stat.done)
                begin
                    k2_next    = alu_res;
                    ar_s       = q_add(tmp_reg, q_half(alu_res));
                    sat_next   = sat_reg | alu_stat.sat | ar_s.sat;
                    st_we      = 1'b1;
                    st_waddr   = st_addr(32'(idx_reg), 32'(j0_reg) + 32'd1);
                    st_wdata   = ar_s.val;
                    state_next = S_FN_W2;
                end
            end
            S_FN_W2:
            begin
                ar_s       = q_add(tmp_reg, k2_reg);
                sat_next   = sat_reg | ar_s.sat;
                st_we      = 1'b1;
                st_waddr   = st_addr(32'(idx_reg), 32'(j0_reg) + 32'd2);
                st_wdata   = ar_s.val;
                idx_next   = idx_reg + CW'(1);
                state_next = S_FN_RD;
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_ld     = 1'b1;
                    st_d       = sat_reg ? ST_SAT : ST_OK;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold control state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            out_valid_reg  <= 1'b0;
            time_count_reg <= '0;
            pred_count_reg <= '0;
            op_count_reg   <= '0;
            step_size_reg  <= '0;
            sat_reg        <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            sat_reg   <= sat_next;
            if (out_ld)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_TIME: time_count_reg <= cfg_data[8:0];
                    CFG_PRED: pred_count_reg <= cfg_data[6:0];
                    CFG_OPS:  op_count_reg   <= cfg_data[6:0];
                    CFG_STEP: step_size_reg  <= cfg_data[62:0];
                    default:  step_size_reg  <= step_size_reg;
                endcase
            end
        end
    end

    // Advance datapath registers
    always_ff @(posedge clk)
    begin
        tc_reg      <= tc_next;
        j0_reg      <= j0_next;
        np_reg      <= np_next;
        idx_reg     <= idx_next;
        nops_reg    <= nops_next;
        k_reg       <= k_next;
        stage_reg   <= stage_next;
        dt_reg      <= dt_next;
        op_reg      <= op_next;
        src_sel_reg <= src_sel_next;
        src_reg     <= src_next;
        tmp_reg     <= tmp_next;
        drv_reg     <= drv_next;
        add_reg     <= add_next;
        k2_reg      <= k2_next;
        heat_on_reg <= heat_on_next;
        if (out_ld)
        begin
            rv_reg <= rv_d;
            st_reg <= st_d;
        end
    end

    assign out_valid  = out_valid_reg;
    assign read_value = rv_reg;
    assign status     = st_reg;
endmodule

// ===== sim/tni_checker.sv =====
// Checker for the thermal network integrator: predicts each result from the items and
// register writes seen on the channels, and compares it with what the block returns.
// Depends on tni_pkg for codes and limits.
`timescale 1ns / 1ps

module tni_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic [1:0]         func,
    input  logic [5:0]         op_index,
    input  logic [2:0]         op_kind,
    input  logic [5:0]         target_node,
    input  logic [5:0]         source_node,
    input  logic [5:0]         power_row,
    input  logic signed [63:0] coef_first,
    input  logic signed [63:0] coef_second,
    input  logic [5:0]         row,
    input  logic [7:0]         column,
    input  logic signed [63:0] value,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic signed [63:0] read_value,
    input  logic [1:0]         status,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [63:0]        cfg_data,
    output int                 errors,
    output int                 outstanding
);
    import tni_pkg::*;

    typedef logic signed [63:0] q_t;

    typedef struct {
        q_t         rv;
        logic [1:0] st;
    } answer_t;

    // Mirror of the block state
    q_t          cells [0:16383];
    logic [2:0]  kinds [0:63];
    logic [5:0]  tgts [0:63];
    logic [5:0]  srcs [0:63];
    logic [5:0]  pwrs [0:63];
    q_t          c1s [0:63];
    q_t          c2s [0:63];
    q_t          temps [0:63];
    q_t          derivs [0:63];
    logic [8:0]  n_times;
    logic [6:0]  n_pred;
    logic [6:0]  n_ops;
    logic [62:0] dt_reg;
    logic        sat_hit;

    answer_t answers[$];

    assign outstanding = answers.size();

    function automatic logic [63:0] mag(q_t v);
        return v[63] ? (~v + 64'd1) : v;
    endfunction

    // Apply sign to a magnitude, saturating
    function automatic q_t fit(logic [63:0] m, logic neg, logic over);
        if (neg) begin
            if (over || m > 64'h8000_0000_0000_0000) begin
                sat_hit = 1'b1;
                return Q_MIN;
            end
            return -m;
        end
        if (over || m[63]) begin
            sat_hit = 1'b1;
            return Q_MAX;
        end
        return m;
    endfunction

    function automatic q_t sadd(q_t a, q_t b);
        logic [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63]) begin
            sat_hit = 1'b1;
            return s[64] ? Q_MIN : Q_MAX;
        end
        return s[63:0];
    endfunction

    function automatic q_t ssub(q_t a, q_t b);
        logic [64:0] s;
        s = {a[63], a} - {b[63], b};
        if (s[64] != s[63]) begin
            sat_hit = 1'b1;
            return s[64] ? Q_MIN : Q_MAX;
        end
        return s[63:0];
    endfunction

    function automatic q_t smul(q_t a, q_t b);
        logic [127:0] prod;
        prod = {64'd0, mag(a)} * {64'd0, mag(b)};
        return fit(prod[95:32], a[63] ^ b[63], prod[127:96] != 0);
    endfunction

    function automatic q_t sdiv(q_t a, q_t b);
        logic [127:0] quo;
        if (b == 0) begin
            sat_hit = 1'b1;
            return a[63] ? Q_MIN : Q_MAX;
        end
        quo = {32'd0, mag(a), 32'd0} / {64'd0, mag(b)};
        if (quo[127:64] != 0)
            return fit(64'd0, a[63] ^ b[63], 1'b1);
        return fit(quo[63:0], a[63] ^ b[63], 1'b0);
    endfunction

    // Accumulate the derivatives of the predicted nodes at one column and write the heater power rows
    function automatic void eval_column(int j, int np, int nops);
        q_t sensed, d, pw;
        int t, s, p;
        for (int k = 0; k < nops; k++) begin
            t = tgts[k];
            s = srcs[k];
            p = pwrs[k];
            sensed = (s < np) ? temps[s] : cells[s * 256 + j];
            case (kinds[k])
                K_COUPLE:
                    if (t < np)
                        derivs[t] = sadd(derivs[t], sdiv(ssub(sensed, temps[t]), c1s[k]));
                K_SINK:
                    if (t < np)
                        derivs[t] = sadd(derivs[t], sdiv(ssub(c1s[k], temps[t]), c2s[k]));
                K_HEAT:
                    if (t < np)
                        derivs[t] = sadd(derivs[t], cells[s * 256 + j]);
                K_PHEAT, K_THEAT:
                begin
                    d = ssub(c1s[k], sensed);
                    if (d > 0) begin
                        pw = (kinds[k] == K_PHEAT) ? smul(c2s[k], d) : c2s[k];
                        cells[p * 256 + j] = pw;
                        if (t < np)
                            derivs[t] = sadd(derivs[t], pw);
                    end
                    else begin
                        cells[p * 256 + j] = 0;
                    end
                end
                default: ;
            endcase
        end
    endfunction

    // Integrate the predicted nodes two columns at a time, keeping the midpoint state
    function automatic void integrate();
        int tc, np, nops, j;
        q_t dt, k2;
        tc = (n_times > 256) ? 256 : n_times;
        np = (n_pred > 64) ? 64 : n_pred;
        nops = (n_ops > 64) ? 64 : n_ops;
        dt = {1'b0, dt_reg};
        for (int j0 = 0; j0 + 2 < tc; j0 += 2) begin
            for (int stage = 0; stage < 2; stage++) begin
                j = j0 + stage;
                for (int i = 0; i < np; i++) begin
                    if (stage == 0)
                        temps[i] = cells[i * 256 + j];
                    else
                        temps[i] = sadd(temps[i], smul(dt, derivs[i]) / 2);
                    derivs[i] = 0;
                end
                eval_column(j, np, nops);
            end
            for (int i = 0; i < np; i++) begin
                k2 = smul(dt, derivs[i]);
                cells[i * 256 + j0 + 1] = sadd(temps[i], k2 / 2);
                cells[i * 256 + j0 + 2] = sadd(temps[i], k2);
            end
        end
    endfunction

    task automatic report(string what, q_t got, q_t want);
        errors++;
        if (errors <= 40)
            $display("%0t mismatch on %s: got %h, want %h", $realtime, what, got, want);
    endtask

    initial errors = 0;

    // Track register writes, predict each item and check each result
    always @(posedge clk or negedge rst_n) begin
        answer_t a;
        if (!rst_n) begin
            n_times = 0;
            n_pred = 0;
            n_ops = 0;
            dt_reg = 0;
            answers.delete();
        end
        else begin
            if (out_valid && out_ready) begin
                if (answers.size() == 0) begin
                    report("unexpected result", read_value, 64'sd0);
                end
                else begin
                    a = answers.pop_front();
                    if (read_value !== a.rv)
                        report("read_value", read_value, a.rv);
                    if (status !== a.st)
                        report("status", 64'(status), 64'(a.st));
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_TIME: n_times = cfg_data[8:0];
                    CFG_PRED: n_pred = cfg_data[6:0];
                    CFG_OPS:  n_ops = cfg_data[6:0];
                    CFG_STEP: dt_reg = cfg_data[62:0];
                    default: ;
                endcase
            end
            if (in_valid && in_ready) begin
                a.rv = 0;
                a.st = ST_OK;
                case (func)
                    FN_OP:
                    begin
                        kinds[op_index] = op_kind;
                        tgts[op_index] = target_node;
                        srcs[op_index] = source_node;
                        pwrs[op_index] = power_row;
                        c1s[op_index] = coef_first;
                        c2s[op_index] = coef_second;
                    end
                    FN_WRITE: cells[row * 256 + column] = value;
                    FN_READ:  a.rv = cells[row * 256 + column];
                    default:
                    begin
                        sat_hit = 1'b0;
                        integrate();
                        a.st = sat_hit ? ST_SAT : ST_OK;
                    end
                endcase
                answers.push_back(a);
            end
        end
    end

endmodule

// ===== sim/testbench.sv =====
// Top of the thermal network integrator testbench: clock, reset, stimulus and verdict.
// Depends on tni_pkg, thermal_network_integrator and tni_checker.
`timescale 1ns / 1ps

module testbench;
    import tni_pkg::*;

    typedef logic signed [63:0] q_t;

    typedef struct {
        logic [1:0] fn;
        logic [5:0] idx;
        logic [2:0] kind;
        logic [5:0] tgt;
        logic [5:0] src;
        logic [5:0] pwr;
        q_t         c1;
        q_t         c2;
        logic [5:0] r;
        logic [7:0] c;
        q_t         v;
    } cmd_t;

    localparam int IDLE_LIMIT = 300000;
    localparam int NPHASE = 8;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic [1:0]         func;
    logic [5:0]         op_index;
    logic [2:0]         op_kind;
    logic [5:0]         target_node;
    logic [5:0]         source_node;
    logic [5:0]         power_row;
    logic signed [63:0] coef_first;
    logic signed [63:0] coef_second;
    logic [5:0]         row;
    logic [7:0]         column;
    logic signed [63:0] value;
    logic               out_valid;
    logic               out_ready;
    logic signed [63:0] read_value;
    logic [1:0]         status;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [1:0]         cfg_index;
    logic [63:0]        cfg_data;
    int                 errors;
    int                 outstanding;

    // Store cells known to hold a written value
    bit    filled [0:16383];
    bit    burst;
    int    cur_times, cur_ops;
    int    results_seen;
    int    quiet_cycles;

    thermal_network_integrator DUT (.*);

    tni_checker u_checker (.*);

    initial clk = 1'b0;
    always #1 clk = ~clk;

    function automatic q_t rand_q();
        logic [63:0] m;
        if ($urandom_range(0, 1))
            return {$urandom, $urandom};
        m = {28'd0, 4'($urandom), $urandom};
        return $urandom_range(0, 1) ? -m : m;
    endfunction

    function automatic cmd_t rand_fields();
        cmd_t x;
        x.fn = 2'($urandom);
        x.idx = 6'($urandom);
        x.kind = 3'($urandom);
        x.tgt = 6'($urandom);
        x.src = 6'($urandom);
        x.pwr = 6'($urandom);
        x.c1 = rand_q();
        x.c2 = rand_q();
        x.r = 6'($urandom);
        x.c = 8'($urandom);
        x.v = rand_q();
        return x;
    endfunction

    // Op entry; low entries read only prefilled rows so long runs stay on written cells
    function automatic cmd_t op_cmd(int idx);
        cmd_t x;
        x = rand_fields();
        x.fn = FN_OP;
        x.idx = 6'(idx);
        if (idx < 32)
            x.src = 6'($urandom_range(0, 7));
        return x;
    endfunction

    function automatic cmd_t store_cmd(logic [1:0] fn, int r, int c, q_t v);
        cmd_t x;
        x = rand_fields();
        x.fn = fn;
        x.r = 6'(r);
        x.c = 8'(c);
        x.v = v;
        return x;
    endfunction

    function automatic cmd_t rand_cmd(int run_pct);
        cmd_t x;
        int pick;
        pick = $urandom_range(0, 99);
        x = rand_fields();
        if (pick < run_pct) begin
            x.fn = FN_RUN;
        end
        else if (pick < run_pct + 30) begin
            x = op_cmd($urandom_range(0, 63));
            // keep the active entries of a long time range untouched
            if (cur_times > 16 && x.idx < cur_ops)
                x = op_cmd($urandom_range(cur_ops, 63));
        end
        else if (pick < run_pct + 60) begin
            x.fn = FN_WRITE;
        end
        else begin
            x.fn = FN_READ;
            if (!filled[x.r * 256 + x.c]) begin
                x.r = 6'($urandom_range(0, 7));
                x.c = 8'($urandom_range(0, 15));
            end
        end
        return x;
    endfunction

    // Offer one item after a random gap (none in a burst) and hold it until accepted
    task automatic send(cmd_t x);
        int gap;
        gap = burst ? 0 : $urandom_range(0, 5);
        repeat (gap) begin
            @(negedge clk);
            in_valid = 1'b0;
        end
        @(negedge clk);
        in_valid = 1'b1;
        func = x.fn;
        op_index = x.idx;
        op_kind = x.kind;
        target_node = x.tgt;
        source_node = x.src;
        power_row = x.pwr;
        coef_first = x.c1;
        coef_second = x.c2;
        row = x.r;
        column = x.c;
        value = x.v;
        if (x.fn == FN_WRITE)
            filled[x.r * 256 + x.c] = 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    task automatic write_reg(logic [1:0] idx, logic [63:0] data);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = data;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic drain();
        while (outstanding != 0)
            @(posedge clk);
        repeat (4) @(negedge clk);
    endtask

    // Receiver: random stalls per result, one long hold-off to back the block up
    initial begin
        int w;
        bit held;
        held = 0;
        results_seen = 0;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever begin
            if (!held && results_seen == 120) begin
                held = 1;
                @(negedge clk);
                out_ready = 1'b0;
                repeat (300) @(negedge clk);
            end
            w = burst ? 0 : $urandom_range(0, 5);
            repeat (w) begin
                @(negedge clk);
                out_ready = 1'b0;
            end
            @(negedge clk);
            out_ready = 1'b1;
            do
                @(posedge clk);
            while (!out_valid);
            results_seen++;
        end
    end

    // Watchdog: end the run when nothing moves for too long
    initial begin
        quiet_cycles = 0;
        while (quiet_cycles < IDLE_LIMIT) begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("testbench: FAIL");
        $finish;
    end

    // Main stimulus
    initial begin
        int ph_times [NPHASE];
        int ph_pred [NPHASE];
        int ph_ops [NPHASE];
        int ph_items [NPHASE];
        int ph_runs [NPHASE];
        logic [62:0] steps [NPHASE];
        cmd_t x;

        ph_times = '{6, 4, 0, 3, 16, 8, 256, 5};
        ph_pred = '{4, 64, 0, 3, 8, 2, 1, 7};
        ph_ops = '{6, 64, 0, 10, 32, 4, 1, 8};
        ph_items = '{300, 60, 60, 250, 40, 300, 30, 250};
        ph_runs = '{8, 8, 10, 10, 8, 8, 10, 8};
        steps = '{63'h4000_0000, '1, 63'd0, 63'($urandom), 63'h1000_0000,
                  63'($urandom), 63'h8000_0000, 63'h1_0000_0000};
        burst = 0;
        cur_times = 0;
        cur_ops = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        func = FN_OP;
        op_index = 0;
        op_kind = K_COUPLE;
        target_node = 0;
        source_node = 0;
        power_row = 0;
        coef_first = 0;
        coef_second = 0;
        row = 0;
        column = 0;
        value = 0;
        cfg_valid = 1'b0;
        cfg_index = CFG_TIME;
        cfg_data = 0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Load every table entry and the store region the runs read
        for (int k = 0; k < 64; k++)
            send(op_cmd(k));
        for (int r = 0; r < 64; r++)
            for (int c = 0; c < 2; c++)
                send(store_cmd(FN_WRITE, r, c, rand_q()));
        for (int r = 0; r < 8; r++)
            for (int c = 2; c < 16; c++)
                send(store_cmd(FN_WRITE, r, c, rand_q()));

        // Store extremes
        send(store_cmd(FN_WRITE, 63, 255, Q_MIN));
        send(store_cmd(FN_READ, 63, 255, 0));
        send(store_cmd(FN_WRITE, 0, 0, Q_MAX));
        send(store_cmd(FN_READ, 0, 0, 0));
        send(store_cmd(FN_READ, 7, 15, 0));

        for (int ph = 0; ph < NPHASE; ph++) begin
            drain();
            if (ph_times[ph] > 16) begin
                // entry 0 as a sink reads no stored column
                x = op_cmd(0);
                x.kind = K_SINK;
                x.src = 0;
                x.tgt = 0;
                x.c2 = 64'sh1_0000_0000;
                send(x);
                drain();
            end
            cur_times = ph_times[ph];
            cur_ops = ph_ops[ph];
            write_reg(CFG_TIME, 64'(ph_times[ph]));
            write_reg(CFG_PRED, 64'(ph_pred[ph]));
            write_reg(CFG_OPS, 64'(ph_ops[ph]));
            write_reg(CFG_STEP, {1'b0, steps[ph]});
            if (ph == 1) begin
                // Divide by zero, unknown kind, coefficient extremes, top rows
                x = op_cmd(32); x.kind = K_COUPLE; x.c1 = 0; send(x);
                x = op_cmd(33); x.kind = K_SINK; x.c2 = 0; x.c1 = Q_MIN; send(x);
                x = op_cmd(34); x.kind = 3'd7; send(x);
                x = op_cmd(35); x.kind = K_THEAT; x.c1 = Q_MAX; x.c2 = Q_MIN; send(x);
                x = op_cmd(36); x.kind = K_PHEAT; x.c1 = Q_MAX; x.c2 = Q_MAX; send(x);
                x = op_cmd(37); x.kind = K_HEAT; x.tgt = 63; x.src = 63; x.pwr = 63;
                send(x);
                x = op_cmd(38); x.kind = K_PHEAT; x.c1 = 64'sh10_0000_0000; x.c2 = 64'sh1000;
                send(x);
                x = rand_fields(); x.fn = FN_RUN; send(x);
            end
            for (int n = 0; n < ph_items[ph]; n++) begin
                if (n % 40 == 0)
                    burst = ($urandom_range(0, 3) == 0);
                send(rand_cmd(ph_runs[ph]));
            end
            burst = 0;
        end

        drain();
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule

// ===== thermal_network_integrator.f =====
hdl/tni_pkg.sv
hdl/tni_ram.sv
hdl/tni_alu.sv
hdl/thermal_network_integrator.sv
sim/tni_checker.sv
sim/testbench.sv
